/* rtl/core/rbp_pkg.sv */
package rbp_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_FRAC = 30;
  localparam int T_W = 48;
  localparam int NUM_W = 33;
  localparam int DIV_NUM_W = NUM_W + DIR_FRAC;
  localparam logic [31:0] PARALLEL_LIMIT = 32'd11;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic [15:0] entity_id;
    logic last_box;
  } box_in_t;

  typedef struct packed {
    logic hit;
    logic any_hit;
    logic [15:0] selected_id;
    logic pick_done;
  } pick_out_t;

endpackage

/* rtl/core/rbp_div.sv */
module rbp_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rbp_pkg::DIV_NUM_W-1:0] num,
  input  logic [31:0] den,
  output logic done,
  output logic [rbp_pkg::DIV_NUM_W-1:0] quo
);
  import rbp_pkg::*;

  logic busy;
  logic [6:0] count;
  logic [32:0] rem;
  logic [33:0] trial;
  logic [32:0] rem_shift;

  assign rem_shift = {rem[31:0], quo[DIV_NUM_W-1]};
  assign trial = {1'b0, rem_shift} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'(DIV_NUM_W);
        rem <= '0;
        quo <= num;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[DIV_NUM_W-2:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/core/ray_box_pick_core.sv */
// Ray against axis-aligned box pick using the slab method in fixed point.
// Load the ray origin (Q16.16) and unit direction (Q2.30) through the
// configuration port, then stream boxes; each box yields one result item
// with its hit flag, the any-hit flag and the id of the first hit box of the
// current pick, and the pick state clears after the box marked last_box.
// One restoring divider, one quotient bit per cycle, serves all six slab
// divisions, each yielding a 63-bit quotient. box_ready is low from the
// time a box is taken until its result item is accepted on res_ready, so
// the next box waits for the current one; fewer divisions run when an
// axis is parallel or the window empties early.
module ray_box_pick_core #(
  parameter int ID_WIDTH = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic box_valid,
  output logic box_ready,
  input  rbp_pkg::box_in_t box,
  output logic res_valid,
  input  logic res_ready,
  output rbp_pkg::pick_out_t res
);
  import rbp_pkg::*;

  // The entity id field is 16 bits wide, so at most 16 id bits are kept.
  localparam int ID_KEEP_W = (ID_WIDTH < 16) ? ID_WIDTH : 16;

  localparam logic signed [T_W-1:0] T_SAT = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN_START =
    T_W'(((64'd1 << COORD_FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AXIS  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  box_in_t cur;
  logic [2:0] state;
  logic [1:0] axis;
  logic side;
  logic missed;
  logic signed [T_W-1:0] t_lo, t_hi, t0, t1;
  logic found;
  logic [ID_KEEP_W-1:0] first_id;

  logic signed [31:0] o_sel, d_sel, bmin_sel, bmax_sel, c_sel;
  logic signed [32:0] num_s;
  logic [32:0] num_mag;
  logic [31:0] den_mag;
  logic neg_q;
  logic div_start, div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic signed [T_W-1:0] t_val, lo_e, hi_e, new_lo, new_hi;
  logic parallel;

  always_comb begin
    case (axis)
      2'd0: begin o_sel = org[0]; d_sel = dir[0];
        bmin_sel = cur.box_min_x; bmax_sel = cur.box_max_x; end
      2'd1: begin o_sel = org[1]; d_sel = dir[1];
        bmin_sel = cur.box_min_y; bmax_sel = cur.box_max_y; end
      default: begin o_sel = org[2]; d_sel = dir[2];
        bmin_sel = cur.box_min_z; bmax_sel = cur.box_max_z; end
    endcase
    c_sel = side ? bmax_sel : bmin_sel;
    num_s = 33'(c_sel) - 33'(o_sel);
    num_mag = num_s[32] ? 33'(-num_s) : num_s;
    den_mag = d_sel[31] ? 32'(-d_sel) : d_sel;
    neg_q = num_s[32] ^ d_sel[31];
    parallel = den_mag < PARALLEL_LIMIT;
  end

  rbp_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({num_mag, {DIR_FRAC{1'b0}}}), .den(den_mag),
    .done(div_done), .quo(div_quo)
  );

  // Saturate and sign the quotient; order t0/t1 and clip the window.
  always_comb begin
    logic [T_W-1:0] mag;
    mag = (div_quo > DIV_NUM_W'(T_SAT)) ? T_SAT : div_quo[T_W-1:0];
    t_val = neg_q ? -$signed(mag) : $signed(mag);
    lo_e = (t0 > t1) ? t1 : t0;
    hi_e = (t0 > t1) ? t0 : t1;
    new_lo = (lo_e > t_lo) ? lo_e : t_lo;
    new_hi = (hi_e < t_hi) ? hi_e : t_hi;
  end

  assign div_start = (state == S_AXIS) && !parallel;
  assign box_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= 32'hC000_0000;
      state <= S_IDLE;
      res_valid <= 1'b0;
      found <= 1'b0;
      first_id <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORG_X: org[0] <= cfg_data;
          REG_ORG_Y: org[1] <= cfg_data;
          REG_ORG_Z: org[2] <= cfg_data;
          REG_DIR_X: dir[0] <= cfg_data;
          REG_DIR_Y: dir[1] <= cfg_data;
          REG_DIR_Z: dir[2] <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (box_valid) begin
            cur <= box;
            axis <= 2'd0;
            side <= 1'b0;
            missed <= 1'b0;
            t_lo <= T_MIN_START;
            t_hi <= T_SAT;
            state <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (parallel) begin
            if (o_sel < bmin_sel || o_sel > bmax_sel) begin
              missed <= 1'b1;
              state <= S_FIN;
            end else begin
              state <= S_NEXT;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            if (!side) begin
              t0 <= t_val;
              side <= 1'b1;
              state <= S_AXIS;
            end else begin
              t1 <= t_val;
              state <= S_FOLD;
            end
          end
        end
        S_FOLD: begin
          t_lo <= new_lo;
          t_hi <= new_hi;
          if (new_lo > new_hi) begin
            missed <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          side <= 1'b0;
          if (axis == 2'd2) begin
            state <= S_FIN;
          end else begin
            axis <= axis + 2'd1;
            state <= S_AXIS;
          end
        end
        S_FIN: begin
          res.hit <= !missed;
          res.pick_done <= cur.last_box;
          if (found) begin
            res.any_hit <= 1'b1;
            res.selected_id <= 16'(first_id);
          end else if (!missed) begin
            res.any_hit <= 1'b1;
            res.selected_id <= 16'(cur.entity_id[ID_KEEP_W-1:0]);
          end else begin
            res.any_hit <= 1'b0;
            res.selected_id <= '0;
          end
          if (cur.last_box) begin
            found <= 1'b0;
            first_id <= '0;
          end else if (!missed && !found) begin
            found <= 1'b1;
            first_id <= cur.entity_id[ID_KEEP_W-1:0];
          end
          res_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
